FILE: src/gcrb_pkg.sv
// Shared constants, types and helper functions for the great-circle range and bearing block.
// No dependencies; every other file imports this package.
package gcrb_pkg;

    localparam int CORDIC_STAGES_DEF = 24;
    localparam int STEPS_PER_STAGE   = 4;

    // degrees*1e7 to binary angle: floor((|v| * 2^22 + DEG_RND) / DEG_DIV)
    localparam logic [21:0] DEG_DIV = 22'd3515625;
    localparam logic [20:0] DEG_RND = 21'd1757812;

    localparam logic signed [33:0] INV_GAIN     = 34'sd652032874;
    localparam logic signed [33:0] QUARTER_TURN = 34'sd1073741824;
    localparam logic signed [33:0] HALF_TURN    = 34'sd2147483648;
    localparam logic [30:0]        ONE_Q30      = 31'h40000000;

    localparam logic [30:0] RANGE_MUL    = 31'd1317679463;
    localparam logic [32:0] RANGE_MAX    = 33'd5270000000;
    localparam logic [23:0] RADIUS_RESET = 24'd6371000;

    typedef logic [31:0]        bang_t;
    typedef logic signed [31:0] q30_t;

    function automatic bang_t atan_entry(input int idx);
        bang_t v;
        unique case (idx)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            24: v = 32'h00000029;
            25: v = 32'h00000014;
            26: v = 32'h0000000A;
            27: v = 32'h00000005;
            28: v = 32'h00000003;
            29: v = 32'h00000001;
            30: v = 32'h00000001;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Q30 product, floor shift by 30
    function automatic q30_t mul_q30(input q30_t a, input q30_t b);
        logic signed [63:0] p;
        p = a * b;
        return p[61:30];
    endfunction

endpackage

FILE: src/great_circle_range_and_bearing.sv
// Throughput: one request per cycle, held while a result waits on m_ready.
// The CORDIC chains, root and multiplier stages are unrolled.
// A stalled result holds every stage in place; nothing is dropped or repeated.
// Reset (aresetn low, synchronous) clears all valid bits and loads a radius of 6371000 m.
// Depends on gcrb_pkg, gcrb_angle_conv, gcrb_sincos, gcrb_isqrt and gcrb_atan2.
module great_circle_range_and_bearing import gcrb_pkg::*; #(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [23:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [30:0] s_from_lat,
    input  logic signed [31:0] s_from_lon,
    input  logic signed [30:0] s_to_lat,
    input  logic signed [31:0] s_to_lon,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [32:0]        m_range_cm,
    output logic signed [15:0] m_bearing_centideg
);

    logic        adv;
    logic [23:0] radius_reg;

    logic signed [31:0] coord [4];
    bang_t              bang [4];
    logic               conv_valid;
    bang_t              sc_ang [5];
    bang_t              dlat;
    bang_t              dlon;
    logic               sc_valid;
    q30_t               sn [5];
    q30_t               cs [5];

    logic [3:0] mul_valid_reg;
    q30_t m1_hp1_reg, m1_hp2_reg, m1_ap1_reg, m1_ap2_reg, m1_ap3_reg;
    q30_t m1_c1_reg, m1_c2_reg, m1_cd_reg;
    q30_t m2_hp1_reg, m2_t2_reg, m2_ap4_reg, m2_c2_reg, m2_ap1_reg, m2_ap2_reg;
    q30_t m3_hp1_reg, m3_t3_reg, m3_azy_reg;
    logic signed [33:0] m3_azx_reg;
    logic [30:0]        a_reg;
    logic [30:0]        a_next;
    logic signed [32:0] a_sum;
    logic signed [33:0] m4_azx_reg;
    q30_t               m4_azy_reg;

    logic [63:0]        rad [2];
    logic               sq_valid;
    logic [30:0]        roots [2];
    logic signed [33:0] sq_azx;
    q30_t               sq_azy;

    logic signed [33:0] at_y [2];
    logic signed [33:0] at_x [2];
    logic               at_valid;
    q30_t               at_ang [2];

    logic [2:0]         fin_valid_reg;
    logic [30:0]        zc;
    logic [54:0]        p_reg;
    logic signed [48:0] bm_reg;
    logic [63:0]        hm_reg;
    logic [52:0]        lm_full;
    logic [30:0]        lm_reg;
    logic signed [48:0] bm_round;
    logic signed [15:0] brg_reg;
    logic [63:0]        rsum;
    logic [32:0]        range_reg;
    logic signed [15:0] brg_out_reg;

    assign adv       = !m_valid || m_ready;
    assign s_ready   = adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= RADIUS_RESET;
        end else if (cfg_valid) begin
            radius_reg <= cfg_data;
        end
    end

    assign coord[0] = 32'(s_from_lat);
    assign coord[1] = s_from_lon;
    assign coord[2] = 32'(s_to_lat);
    assign coord[3] = s_to_lon;

    gcrb_angle_conv #(.LANES(4)) u_conv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (s_valid),
        .coord     (coord),
        .out_valid (conv_valid),
        .bang      (bang)
    );

    assign dlat      = bang[2] - bang[0];
    assign dlon      = bang[3] - bang[1];
    assign sc_ang[0] = bang[0];
    assign sc_ang[1] = bang[2];
    assign sc_ang[2] = dlon;
    assign sc_ang[3] = {1'b0, dlat[31:1]};
    assign sc_ang[4] = {1'b0, dlon[31:1]};

    gcrb_sincos #(.LANES(5), .STAGES(CORDIC_STAGES)) u_sincos (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (conv_valid),
        .ang       (sc_ang),
        .out_valid (sc_valid),
        .sin_out   (sn),
        .cos_out   (cs)
    );

    // haversine and azimuth products, one multiply deep per stage
    assign a_sum  = 33'(m3_hp1_reg) + 33'(m3_t3_reg);
    assign a_next = a_sum[32] ? '0 : (a_sum > 33'(ONE_Q30)) ? ONE_Q30 : a_sum[30:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= '0;
        end else if (adv) begin
            mul_valid_reg <= {mul_valid_reg[2:0], sc_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m1_hp1_reg <= mul_q30(sn[3], sn[3]);
            m1_hp2_reg <= mul_q30(sn[4], sn[4]);
            m1_ap1_reg <= mul_q30(sn[2], cs[1]);
            m1_ap2_reg <= mul_q30(cs[0], sn[1]);
            m1_ap3_reg <= mul_q30(sn[0], cs[1]);
            m1_c1_reg  <= cs[0];
            m1_c2_reg  <= cs[1];
            m1_cd_reg  <= cs[2];

            m2_hp1_reg <= m1_hp1_reg;
            m2_t2_reg  <= mul_q30(m1_hp2_reg, m1_c1_reg);
            m2_ap4_reg <= mul_q30(m1_ap3_reg, m1_cd_reg);
            m2_c2_reg  <= m1_c2_reg;
            m2_ap1_reg <= m1_ap1_reg;
            m2_ap2_reg <= m1_ap2_reg;

            m3_hp1_reg <= m2_hp1_reg;
            m3_t3_reg  <= mul_q30(m2_t2_reg, m2_c2_reg);
            m3_azx_reg <= 34'(m2_ap2_reg) - 34'(m2_ap4_reg);
            m3_azy_reg <= m2_ap1_reg;

            a_reg      <= a_next;
            m4_azx_reg <= m3_azx_reg;
            m4_azy_reg <= m3_azy_reg;
        end
    end

    assign rad[0] = {3'b000, a_reg, 30'b0};
    assign rad[1] = {3'b000, 31'(ONE_Q30 - a_reg), 30'b0};

    gcrb_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (mul_valid_reg[3]),
        .radicand  (rad),
        .az_x_in   (m4_azx_reg),
        .az_y_in   (m4_azy_reg),
        .out_valid (sq_valid),
        .root      (roots),
        .az_x_out  (sq_azx),
        .az_y_out  (sq_azy)
    );

    assign at_y[0] = $signed({3'b000, roots[0]});
    assign at_x[0] = $signed({3'b000, roots[1]});
    assign at_y[1] = 34'(sq_azy);
    assign at_x[1] = sq_azx;

    gcrb_atan2 #(.STAGES(CORDIC_STAGES)) u_atan2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (sq_valid),
        .y_in      (at_y),
        .x_in      (at_x),
        .out_valid (at_valid),
        .ang       (at_ang)
    );

    // clamp the central half-angle to a quarter turn
    assign zc = at_ang[0][31] ? '0 :
                (at_ang[0] > 32'sd1073741824) ? ONE_Q30 : at_ang[0][30:0];

    assign lm_full  = 53'(p_reg[21:0]) * 53'(RANGE_MUL);
    assign bm_round = bm_reg + 49'sd2147483648;
    assign rsum     = hm_reg + 64'(lm_reg) + 64'h20000000;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_valid_reg <= '0;
        end else if (adv) begin
            fin_valid_reg <= {fin_valid_reg[1:0], at_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p_reg       <= 55'(radius_reg) * 55'(zc);
            bm_reg      <= 49'(at_ang[1]) * 49'sd36000;

            hm_reg      <= 64'(p_reg[54:22]) * 64'(RANGE_MUL);
            lm_reg      <= lm_full[52:22];
            brg_reg     <= bm_round[47:32];

            range_reg   <= (rsum[63:30] > 34'(RANGE_MAX)) ? RANGE_MAX : rsum[62:30];
            brg_out_reg <= brg_reg;
        end
    end

    assign m_valid            = fin_valid_reg[2];
    assign m_range_cm         = range_reg;
    assign m_bearing_centideg = brg_out_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_range_cm <= RANGE_MAX))
        else $error("range above saturation bound");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_bearing_centideg >= -16'sd18000 && m_bearing_centideg <= 16'sd18000))
        else $error("bearing outside half-turn span");

    assert property (@(posedge aclk) disable iff (!aresetn)
        mul_valid_reg[3] |-> (a_reg <= ONE_Q30))
        else $error("haversine term not clamped");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> ($stable(a_reg) && $stable(p_reg) && $stable(mul_valid_reg)))
        else $error("pipeline moved during stall");

endmodule

FILE: src/gcrb_angle_conv.sv
// Pipelined conversion of 1e-7 degree coordinates to 32-bit binary angles.
// Divides by a constant with a reciprocal multiply and a remainder fix-up; depends on gcrb_pkg.
module gcrb_angle_conv import gcrb_pkg::*; #(
    parameter int LANES = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic signed [31:0] coord [LANES],
    output logic              out_valid,
    output bang_t             bang [LANES]
);

    // floor(2^53 / DEG_DIV): the quotient estimate comes out low by at most two
    localparam logic [31:0] DEG_RECIP = 32'd2562047788;

    logic [3:0]  valid_reg;
    logic [53:0] num1_reg  [LANES];
    logic [53:0] num1_next [LANES];
    logic [31:0] est1_reg  [LANES];
    logic [31:0] est1_next [LANES];
    logic        neg1_reg  [LANES];
    logic        neg1_next [LANES];
    logic [53:0] num2_reg  [LANES];
    logic [53:0] num2_next [LANES];
    logic [53:0] prod_reg  [LANES];
    logic [53:0] prod_next [LANES];
    logic [31:0] est2_reg  [LANES];
    logic [31:0] est2_next [LANES];
    logic        neg2_reg  [LANES];
    logic        neg2_next [LANES];
    logic [31:0] quo_reg   [LANES];
    logic [31:0] quo_next  [LANES];
    logic        neg3_reg  [LANES];
    logic        neg3_next [LANES];
    bang_t       bang_reg  [LANES];
    bang_t       bang_next [LANES];

    always_comb begin
        logic [31:0] mag;
        logic [63:0] scaled;
        logic [53:0] rem;
        for (int l = 0; l < LANES; l++) begin
            mag = coord[l][31] ? 32'(-coord[l]) : 32'(coord[l]);
            scaled = 64'(mag) * 64'(DEG_RECIP);
            num1_next[l] = {mag, 22'b0} + 54'(DEG_RND);
            est1_next[l] = scaled[62:31];
            neg1_next[l] = coord[l][31];

            num2_next[l] = num1_reg[l];
            prod_next[l] = 54'(est1_reg[l]) * 54'(DEG_DIV);
            est2_next[l] = est1_reg[l];
            neg2_next[l] = neg1_reg[l];

            // remainder is below three divisors; step the estimate up to the floor
            rem = num2_reg[l] - prod_reg[l];
            priority if (rem >= 54'({DEG_DIV, 1'b0})) begin
                quo_next[l] = est2_reg[l] + 32'd2;
            end else if (rem >= 54'(DEG_DIV)) begin
                quo_next[l] = est2_reg[l] + 32'd1;
            end else begin
                quo_next[l] = est2_reg[l];
            end
            neg3_next[l] = neg2_reg[l];

            bang_next[l] = neg3_reg[l] ? 32'(-quo_reg[l]) : quo_reg[l];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num1_reg <= num1_next;
            est1_reg <= est1_next;
            neg1_reg <= neg1_next;
            num2_reg <= num2_next;
            prod_reg <= prod_next;
            est2_reg <= est2_next;
            neg2_reg <= neg2_next;
            quo_reg  <= quo_next;
            neg3_reg <= neg3_next;
            bang_reg <= bang_next;
        end
    end

    assign out_valid = valid_reg[3];
    assign bang      = bang_reg;

endmodule

FILE: src/gcrb_sincos.sv
// Unrolled rotation-mode CORDIC giving Q30 sine and cosine of binary angles, one stage per iteration.
// Depends on gcrb_pkg for the arctangent table and constants.
module gcrb_sincos import gcrb_pkg::*; #(
    parameter int LANES  = 5,
    parameter int STAGES = CORDIC_STAGES_DEF
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  logic  in_valid,
    input  bang_t ang [LANES],
    output logic  out_valid,
    output q30_t  sin_out [LANES],
    output q30_t  cos_out [LANES]
);

    logic [STAGES+1:0] valid_reg;
    logic signed [33:0] x_reg  [0:STAGES][LANES];
    logic signed [33:0] y_reg  [0:STAGES][LANES];
    logic signed [33:0] z_reg  [0:STAGES][LANES];
    logic               neg_reg [0:STAGES][LANES];
    logic signed [33:0] x_next [0:STAGES][LANES];
    logic signed [33:0] y_next [0:STAGES][LANES];
    logic signed [33:0] z_next [0:STAGES][LANES];
    logic               neg_next [0:STAGES][LANES];
    q30_t sin_reg [LANES];
    q30_t cos_reg [LANES];
    q30_t sin_next [LANES];
    q30_t cos_next [LANES];

    always_comb begin
        logic signed [33:0] zs;
        logic signed [33:0] step;
        for (int l = 0; l < LANES; l++) begin
            zs = 34'(signed'(ang[l]));
            x_next[0][l] = INV_GAIN;
            y_next[0][l] = '0;
            // fold into the right half plane, flip results afterwards
            if (zs > QUARTER_TURN) begin
                z_next[0][l]   = zs - HALF_TURN;
                neg_next[0][l] = 1'b1;
            end else if (zs < -QUARTER_TURN) begin
                z_next[0][l]   = zs + HALF_TURN;
                neg_next[0][l] = 1'b1;
            end else begin
                z_next[0][l]   = zs;
                neg_next[0][l] = 1'b0;
            end
        end
        for (int s = 1; s <= STAGES; s++) begin
            step = $signed({2'b00, atan_entry(s - 1)});
            for (int l = 0; l < LANES; l++) begin
                neg_next[s][l] = neg_reg[s-1][l];
                if (!z_reg[s-1][l][33]) begin
                    x_next[s][l] = x_reg[s-1][l] - (y_reg[s-1][l] >>> (s - 1));
                    y_next[s][l] = y_reg[s-1][l] + (x_reg[s-1][l] >>> (s - 1));
                    z_next[s][l] = z_reg[s-1][l] - step;
                end else begin
                    x_next[s][l] = x_reg[s-1][l] + (y_reg[s-1][l] >>> (s - 1));
                    y_next[s][l] = y_reg[s-1][l] - (x_reg[s-1][l] >>> (s - 1));
                    z_next[s][l] = z_reg[s-1][l] + step;
                end
            end
        end
        for (int l = 0; l < LANES; l++) begin
            sin_next[l] = neg_reg[STAGES][l] ? 32'(-y_reg[STAGES][l]) : 32'(y_reg[STAGES][l]);
            cos_next[l] = neg_reg[STAGES][l] ? 32'(-x_reg[STAGES][l]) : 32'(x_reg[STAGES][l]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[STAGES:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
            neg_reg <= neg_next;
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    assign out_valid = valid_reg[STAGES+1];
    assign sin_out   = sin_reg;
    assign cos_out   = cos_reg;

endmodule

FILE: src/gcrb_isqrt.sv
// Pipelined digit-by-digit integer square root, two lanes, several root bits per stage.
// Carries the azimuth operands alongside; depends on gcrb_pkg.
module gcrb_isqrt import gcrb_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  logic [63:0]        radicand [2],
    input  logic signed [33:0] az_x_in,
    input  q30_t               az_y_in,
    output logic               out_valid,
    output logic [30:0]        root [2],
    output logic signed [33:0] az_x_out,
    output q30_t               az_y_out
);

    localparam int NSTG = 32 / STEPS_PER_STAGE;

    logic [NSTG-1:0] valid_reg;
    logic [32:0] rem_reg   [0:NSTG-1][2];
    logic [31:0] root_reg  [0:NSTG-1][2];
    logic [63:0] rad_reg   [0:NSTG-1][2];
    logic [32:0] rem_next  [0:NSTG-1][2];
    logic [31:0] root_next [0:NSTG-1][2];
    logic [63:0] rad_next  [0:NSTG-1][2];
    logic signed [33:0] azx_reg [0:NSTG-1];
    q30_t               azy_reg [0:NSTG-1];

    always_comb begin
        logic [34:0] t;
        logic [34:0] trial;
        for (int s = 0; s < NSTG; s++) begin
            for (int l = 0; l < 2; l++) begin
                if (s == 0) begin
                    rem_next[s][l]  = '0;
                    root_next[s][l] = '0;
                    rad_next[s][l]  = radicand[l];
                end else begin
                    rem_next[s][l]  = rem_reg[s-1][l];
                    root_next[s][l] = root_reg[s-1][l];
                    rad_next[s][l]  = rad_reg[s-1][l];
                end
                for (int k = 0; k < STEPS_PER_STAGE; k++) begin
                    t     = {rem_next[s][l], rad_next[s][l][63:62]};
                    trial = {1'b0, root_next[s][l], 2'b01};
                    rad_next[s][l] = {rad_next[s][l][61:0], 2'b00};
                    if (t >= trial) begin
                        t = t - trial;
                        root_next[s][l] = {root_next[s][l][30:0], 1'b1};
                    end else begin
                        root_next[s][l] = {root_next[s][l][30:0], 1'b0};
                    end
                    rem_next[s][l] = t[32:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[NSTG-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg    <= rem_next;
            root_reg   <= root_next;
            rad_reg    <= rad_next;
            azx_reg[0] <= az_x_in;
            azy_reg[0] <= az_y_in;
            for (int s = 1; s < NSTG; s++) begin
                azx_reg[s] <= azx_reg[s-1];
                azy_reg[s] <= azy_reg[s-1];
            end
        end
    end

    assign out_valid = valid_reg[NSTG-1];
    assign root[0]   = root_reg[NSTG-1][0][30:0];
    assign root[1]   = root_reg[NSTG-1][1][30:0];
    assign az_x_out  = azx_reg[NSTG-1];
    assign az_y_out  = azy_reg[NSTG-1];

endmodule

FILE: src/gcrb_atan2.sv
// Unrolled vectoring-mode CORDIC computing atan2 as a signed 32-bit binary angle, two lanes.
// Depends on gcrb_pkg for the arctangent table and constants.
module gcrb_atan2 import gcrb_pkg::*; #(
    parameter int STAGES = CORDIC_STAGES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  logic signed [33:0] y_in [2],
    input  logic signed [33:0] x_in [2],
    output logic               out_valid,
    output q30_t               ang [2]
);

    logic [STAGES+1:0] valid_reg;
    logic signed [35:0] x_reg  [0:STAGES][2];
    logic signed [35:0] y_reg  [0:STAGES][2];
    logic signed [33:0] z_reg  [0:STAGES][2];
    logic               zero_reg [0:STAGES][2];
    logic signed [35:0] x_next [0:STAGES][2];
    logic signed [35:0] y_next [0:STAGES][2];
    logic signed [33:0] z_next [0:STAGES][2];
    logic               zero_next [0:STAGES][2];
    q30_t ang_reg  [2];
    q30_t ang_next [2];

    always_comb begin
        logic signed [35:0] x0;
        logic signed [35:0] y0;
        logic signed [33:0] step;
        for (int l = 0; l < 2; l++) begin
            x0 = 36'(x_in[l]);
            y0 = 36'(y_in[l]);
            zero_next[0][l] = (x_in[l] == '0) && (y_in[l] == '0);
            // pre-rotate by a half turn for the left half plane
            if (x0 < 0) begin
                x_next[0][l] = -x0;
                y_next[0][l] = -y0;
                z_next[0][l] = HALF_TURN;
            end else begin
                x_next[0][l] = x0;
                y_next[0][l] = y0;
                z_next[0][l] = '0;
            end
        end
        for (int s = 1; s <= STAGES; s++) begin
            step = $signed({2'b00, atan_entry(s - 1)});
            for (int l = 0; l < 2; l++) begin
                zero_next[s][l] = zero_reg[s-1][l];
                if (!y_reg[s-1][l][35]) begin
                    x_next[s][l] = x_reg[s-1][l] + (y_reg[s-1][l] >>> (s - 1));
                    y_next[s][l] = y_reg[s-1][l] - (x_reg[s-1][l] >>> (s - 1));
                    z_next[s][l] = z_reg[s-1][l] + step;
                end else begin
                    x_next[s][l] = x_reg[s-1][l] - (y_reg[s-1][l] >>> (s - 1));
                    y_next[s][l] = y_reg[s-1][l] + (x_reg[s-1][l] >>> (s - 1));
                    z_next[s][l] = z_reg[s-1][l] - step;
                end
            end
        end
        for (int l = 0; l < 2; l++) begin
            ang_next[l] = zero_reg[STAGES][l] ? '0 : z_reg[STAGES][l][31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[STAGES:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            zero_reg <= zero_next;
            ang_reg  <= ang_next;
        end
    end

    assign out_valid = valid_reg[STAGES+1];
    assign ang       = ang_reg;

endmodule

FILE: verif/tb.sv
// Self-checking bench for great_circle_range_and_bearing: directed, radius, random and back-to-back tests.
// Holds its own bit-exact model of the range and bearing math; imports gcrb_pkg for constants.
module tb import gcrb_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSTAGES = (CORDIC_STAGES_DEF > 40) ? 40 : CORDIC_STAGES_DEF;
    localparam longint QTR = 64'sd1073741824;
    localparam longint HLF = 64'sd2147483648;
    localparam longint ARCTAN [0:39] = '{
        'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
        'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
        'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
        'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051,
        'h00000029, 'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001,
        'h00000001, 0, 0, 0, 0, 0, 0, 0, 0, 0};

    typedef struct packed {
        logic [32:0]        range_cm;
        logic signed [15:0] bearing;
    } fix_t;

    logic               aclk = 0;
    logic               aresetn = 0;
    logic               cfg_valid = 0;
    logic               cfg_ready;
    logic [23:0]        cfg_data = '0;
    logic               s_valid = 0;
    logic               s_ready;
    logic signed [30:0] s_from_lat = '0;
    logic signed [31:0] s_from_lon = '0;
    logic signed [30:0] s_to_lat = '0;
    logic signed [31:0] s_to_lon = '0;
    logic               m_valid;
    logic               m_ready = 0;
    logic [32:0]        m_range_cm;
    logic signed [15:0] m_bearing_centideg;

    logic [23:0] radius_m = RADIUS_RESET;
    fix_t        pending_fixes[$];
    int          mismatches = 0;
    bit          no_idle = 0;
    int          stall_left = 0;

    great_circle_range_and_bearing dut (.*);

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [31:0] deg_to_bang(longint v);
        longint unsigned m, q;
        logic [31:0] r;
        m = (v < 0) ? -v : v;
        q = ((m << 22) + 1757812) / 3515625;
        r = q[31:0];
        return (v < 0) ? -r : r;
    endfunction

    function automatic void sincos(logic [31:0] ang, output longint sn, output longint cs);
        longint z, x, y, dx, dy;
        bit flip;
        z = longint'(signed'(ang));
        x = 652032874;
        y = 0;
        flip = 0;
        if (z > QTR) begin
            z -= HLF; flip = 1;
        end else if (z < -QTR) begin
            z += HLF; flip = 1;
        end
        for (int i = 0; i < NSTAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ARCTAN[i];
            end else begin
                x += dx; y -= dy; z += ARCTAN[i];
            end
        end
        sn = flip ? -y : y;
        cs = flip ? -x : x;
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint z, dx, dy;
        logic [63:0] zu;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            x = -x; y = -y; z = HLF;
        end
        for (int i = 0; i < NSTAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += ARCTAN[i];
            end else begin
                x -= dx; y += dy; z -= ARCTAN[i];
            end
        end
        zu = z;
        return longint'(signed'(zu[31:0]));
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b; r = (r >> 1) + b;
            end else r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic fix_t predict_fix(logic signed [30:0] flat, logic signed [31:0] flon,
                                         logic signed [30:0] tlat, logic signed [31:0] tlon);
        logic [31:0] lat1, lon1, lat2, lon2, dlat, dlon;
        longint s1, c1, s2, c2, sd, cd, sh1, ch1, sh2, ch2, a, t, z, y, x, b;
        longint unsigned sa, sb, p, hi, lo, rng;
        fix_t f;
        lat1 = deg_to_bang(flat);
        lon1 = deg_to_bang(flon);
        lat2 = deg_to_bang(tlat);
        lon2 = deg_to_bang(tlon);
        dlat = lat2 - lat1;
        dlon = lon2 - lon1;
        sincos(lat1, s1, c1);
        sincos(lat2, s2, c2);
        sincos(dlon, sd, cd);
        sincos(dlat >> 1, sh1, ch1);
        sincos(dlon >> 1, sh2, ch2);
        a = (sh1 * sh1) >>> 30;
        t = (sh2 * sh2) >>> 30;
        t = (t * c1) >>> 30;
        t = (t * c2) >>> 30;
        a += t;
        if (a < 0) a = 0;
        if (a > QTR) a = QTR;
        sa = int_sqrt(longint'(a) << 30);
        sb = int_sqrt(longint'(QTR - a) << 30);
        z = vector_angle(sa, sb);
        if (z < 0) z = 0;
        if (z > QTR) z = QTR;
        p = longint'(radius_m) * z;
        hi = p >> 22;
        lo = p & 64'h3FFFFF;
        rng = (hi * 1317679463 + ((lo * 1317679463) >> 22) + (64'd1 << 29)) >> 30;
        if (rng > 64'd5270000000) rng = 64'd5270000000;
        y = (sd * c2) >>> 30;
        x = ((c1 * s2) >>> 30) - ((((s1 * c2) >>> 30) * cd) >>> 30);
        b = vector_angle(y, x);
        b = (b * 36000 + HLF) >>> 32;
        f.range_cm = rng[32:0];
        f.bearing = b[15:0];
        return f;
    endfunction

    // result side: random stall bursts, none in the final phase
    always @(posedge aclk) begin
        if (no_idle || !aresetn) begin
            m_ready <= 1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 3);
            m_ready <= 0;
        end else begin
            m_ready <= 1;
        end
    end

    always @(posedge aclk) begin
        fix_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_fixes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result range=%0d bearing=%0d",
                             m_range_cm, m_bearing_centideg);
            end else begin
                want = pending_fixes.pop_front();
                if (m_range_cm !== want.range_cm || m_bearing_centideg !== want.bearing) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: range exp %0d got %0d, bearing exp %0d got %0d",
                                 want.range_cm, m_range_cm, want.bearing, m_bearing_centideg);
                end
            end
        end
    end

    task automatic send_request(logic signed [30:0] flat, logic signed [31:0] flon,
                                logic signed [30:0] tlat, logic signed [31:0] tlon);
        int gap;
        if (!no_idle && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 4);
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1;
        s_from_lat <= flat;
        s_from_lon <= flon;
        s_to_lat <= tlat;
        s_to_lon <= tlon;
        do @(posedge aclk); while (!s_ready);
        pending_fixes.push_back(predict_fix(flat, flon, tlat, tlon));
    endtask

    task automatic drain();
        s_valid <= 0;
        while (pending_fixes.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_radius(logic [23:0] r);
        drain();
        cfg_valid <= 1;
        cfg_data <= r;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        radius_m = r;
    endtask

    function automatic logic signed [30:0] rand_lat();
        return 31'(int'($urandom_range(0, 1800000000)) - 900000000);
    endfunction

    function automatic int rand_lon();
        return int'($urandom_range(0, 2000000000)) + int'($urandom_range(0, 1600000000))
               - 1800000000;
    endfunction

    task automatic test_special_points();
        send_request(0, 0, 0, 0);
        send_request(123456789, -987654321, 123456789, -987654321);
        send_request(900000000, 0, -900000000, 0);
        send_request(900000000, 100, 900000000, -100);
        send_request(-900000000, 0, 450000000, 900000000);
        send_request(0, 0, 0, 1800000000);
        send_request(0, -1800000000, 0, 1800000000);
        send_request(0, 0, 10, 0);
        send_request(0, 0, 0, 10);
        send_request(0, 0, -10, 0);
        send_request(0, 0, 0, -10);
        send_request(515000000, -1200000, 407000000, -740000000);
        // out-of-range coordinates wrap as angles
        send_request(31'sh3FFFFFFF, 32'sh7FFFFFFF, 31'sh40000000, 32'sh80000000);
        send_request(31'sh40000000, 32'sh80000000, 31'sh3FFFFFFF, 32'sh7FFFFFFF);
        send_request(-1, -1, 1, 1);
    endtask

    task automatic test_radius_settings();
        logic [23:0] radii [5] = '{24'd1, 24'hFFFFFF, 24'd0, 24'd6378137, 24'd0};
        radii[4] = 24'($urandom_range(1, 24'hFFFFFF));
        foreach (radii[k]) begin
            write_radius(radii[k]);
            send_request(0, 0, 0, 1800000000);
            send_request(900000000, 0, -900000000, 0);
            send_request(rand_lat(), rand_lon(), rand_lat(), rand_lon());
            send_request(0, 0, 0, 1);
        end
        write_radius(RADIUS_RESET);
    endtask

    task automatic test_random_stream(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_request(31'($urandom), $urandom, 31'($urandom), $urandom);
            else if ($urandom_range(0, 4) == 0)
                // nearly equal longitudes stress the small-angle end of the longitude difference
                send_request(rand_lat(), 1000, rand_lat() / 4096, $urandom_range(0, 4000));
            else
                send_request(rand_lat(), rand_lon(), rand_lat(), rand_lon());
            if (i == n / 2) write_radius(24'($urandom_range(1, 24'hFFFFFF)));
        end
    endtask

    task automatic test_back_to_back(int n);
        drain();
        no_idle = 1;
        write_radius(24'($urandom_range(1, 24'hFFFFFF)));
        for (int i = 0; i < n; i++)
            send_request(rand_lat(), rand_lon(), rand_lat(), rand_lon());
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        test_special_points();
        test_radius_settings();
        test_random_stream(320);
        test_back_to_back(80);
        drain();
        repeat (120) @(posedge aclk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
